// ===== hdl/msl_pkg.sv =====
package msl_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int BND_W      = CNT_W + 1;
    localparam int DATA_W     = 32;
    localparam int RES_W      = DATA_W + 1;

    typedef enum logic [1:0] {
        ACT_PUSH_FIRST  = 2'd0,
        ACT_PUSH_SECOND = 2'd1,
        ACT_COMPUTE     = 2'd2,
        ACT_NONE        = 2'd3
    } msl_action_t;

    typedef struct packed {
        logic push_first;
        logic push_second;
        logic init;
        logic calc_mid;
        logic read;
        logic eval;
        logic finish_empty;
        logic finish_fail;
    } msl_cmd_t;

    typedef struct packed {
        logic empty;
        logic range_done;
        logic found;
    } msl_status_t;

endpackage

// ===== hdl/msl_ctrl.sv =====
module msl_ctrl
    import msl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  action,
    input  msl_status_t status,
    output msl_cmd_t    cmd,
    output logic        busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (msl_action_t'(action))
                        ACT_PUSH_FIRST:  cmd.push_first  = 1'b1;
                        ACT_PUSH_SECOND: cmd.push_second = 1'b1;
                        ACT_COMPUTE:
                        begin
                            if (status.empty)
                            begin
                                cmd.finish_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.init   = 1'b1;
                                state_next = ST_CHECK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (status.range_done)
                begin
                    cmd.finish_fail = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.calc_mid = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.found ? ST_IDLE : ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != ST_IDLE))
        else $error("busy out of step with state");

    a_no_push_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !(cmd.push_first || cmd.push_second))
        else $error("store write during search");

    a_found_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && status.found) |=> !busy_reg)
        else $error("search did not end on a valid cut");

endmodule

// ===== hdl/msl_datapath.sv =====
module msl_datapath
    import msl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] value,
    input  msl_cmd_t                 cmd,
    output msl_status_t              status,
    output logic signed [RES_W-1:0]  median_doubled,
    output logic                     empty_error,
    output logic                     done
);

    logic [DATA_W-1:0] first_mem  [LIST_DEPTH];
    logic [DATA_W-1:0] second_mem [LIST_DEPTH];

    logic [CNT_W-1:0] first_count_reg;
    logic [CNT_W-1:0] second_count_reg;

    logic                    swap_reg;
    logic [CNT_W-1:0]        na_reg;
    logic [CNT_W-1:0]        nb_reg;
    logic [CNT_W-1:0]        left_reg;
    logic                    odd_reg;
    logic signed [BND_W-1:0] low_reg;
    logic signed [BND_W-1:0] high_reg;
    logic [CNT_W-1:0]        m1_reg;
    logic [CNT_W-1:0]        m2_reg;

    logic [DATA_W-1:0] first_rd0_reg;
    logic [DATA_W-1:0] first_rd1_reg;
    logic [DATA_W-1:0] second_rd0_reg;
    logic [DATA_W-1:0] second_rd1_reg;

    logic signed [RES_W-1:0] median_reg;
    logic                    error_reg;
    logic                    done_reg;

    logic [CNT_W:0]          total;
    logic signed [BND_W:0]   mid_sum;
    logic [CNT_W-1:0]        m1_next;
    logic [CNT_W:0]          m2_wide;
    logic [ADDR_W-1:0]       a_lo_addr;
    logic [ADDR_W-1:0]       a_hi_addr;
    logic [ADDR_W-1:0]       b_lo_addr;
    logic [ADDR_W-1:0]       b_hi_addr;
    logic signed [DATA_W-1:0] l1;
    logic signed [DATA_W-1:0] r1;
    logic signed [DATA_W-1:0] l2;
    logic signed [DATA_W-1:0] r2;
    logic                    l1_none;
    logic                    r1_none;
    logic                    l2_none;
    logic                    r2_none;
    logic                    le_12;
    logic                    le_21;
    logic                    found;
    logic signed [DATA_W-1:0] lo_max;
    logic signed [DATA_W-1:0] hi_min;
    logic signed [RES_W-1:0]  median_calc;
    logic                    finish;

    assign total   = {1'b0, first_count_reg} + {1'b0, second_count_reg};
    assign mid_sum = {low_reg[BND_W-1], low_reg} + {high_reg[BND_W-1], high_reg};
    // both bounds are non-negative whenever a midpoint is taken
    assign m1_next = mid_sum[CNT_W:1];
    assign m2_wide = {1'b0, left_reg} - {1'b0, m1_next};

    assign a_lo_addr = ADDR_W'(m1_reg - 1'b1);
    assign a_hi_addr = m1_reg[ADDR_W-1:0];
    assign b_lo_addr = ADDR_W'(m2_reg - 1'b1);
    assign b_hi_addr = m2_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push_first && (first_count_reg < CNT_W'(LIST_DEPTH)))
        begin
            first_mem[first_count_reg[ADDR_W-1:0]] <= value;
        end
        if (cmd.read)
        begin
            first_rd0_reg <= first_mem[swap_reg ? b_lo_addr : a_lo_addr];
            first_rd1_reg <= first_mem[swap_reg ? b_hi_addr : a_hi_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_second && (second_count_reg < CNT_W'(LIST_DEPTH)))
        begin
            second_mem[second_count_reg[ADDR_W-1:0]] <= value;
        end
        if (cmd.read)
        begin
            second_rd0_reg <= second_mem[swap_reg ? a_lo_addr : b_lo_addr];
            second_rd1_reg <= second_mem[swap_reg ? a_hi_addr : b_hi_addr];
        end
    end

    // map the stored words back onto the shorter and longer list
    always_comb
    begin
        l1 = swap_reg ? second_rd0_reg : first_rd0_reg;
        r1 = swap_reg ? second_rd1_reg : first_rd1_reg;
        l2 = swap_reg ? first_rd0_reg  : second_rd0_reg;
        r2 = swap_reg ? first_rd1_reg  : second_rd1_reg;

        l1_none = (m1_reg == '0);
        r1_none = (m1_reg >= na_reg);
        l2_none = (m2_reg == '0);
        r2_none = (m2_reg >= nb_reg);

        le_12 = l1_none || r2_none || (l1 <= r2);
        le_21 = l2_none || r1_none || (l2 <= r1);
        found = le_12 && le_21;

        if (l1_none)
            lo_max = l2;
        else if (l2_none)
            lo_max = l1;
        else
            lo_max = (l1 > l2) ? l1 : l2;

        if (r1_none)
            hi_min = r2;
        else if (r2_none)
            hi_min = r1;
        else
            hi_min = (r1 < r2) ? r1 : r2;

        if (odd_reg)
            median_calc = {lo_max, 1'b0};
        else
            median_calc = {lo_max[DATA_W-1], lo_max} + {hi_min[DATA_W-1], hi_min};
    end

    assign finish = cmd.finish_empty || cmd.finish_fail || (cmd.eval && found);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            low_reg          <= '0;
            high_reg         <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (finish)
            begin
                first_count_reg  <= '0;
                second_count_reg <= '0;
            end
            else
            begin
                if (cmd.push_first && (first_count_reg < CNT_W'(LIST_DEPTH)))
                    first_count_reg <= first_count_reg + 1'b1;
                if (cmd.push_second && (second_count_reg < CNT_W'(LIST_DEPTH)))
                    second_count_reg <= second_count_reg + 1'b1;
            end
            if (cmd.init)
            begin
                low_reg  <= '0;
                high_reg <= (first_count_reg > second_count_reg)
                          ? $signed({1'b0, second_count_reg})
                          : $signed({1'b0, first_count_reg});
            end
            else if (cmd.eval && !found)
            begin
                // move the cut left when the shorter list's left neighbour is too big
                if (!le_12)
                    high_reg <= $signed({1'b0, m1_reg}) - $signed(BND_W'(1));
                else
                    low_reg  <= $signed({1'b0, m1_reg}) + $signed(BND_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            swap_reg <= (first_count_reg > second_count_reg);
            na_reg   <= (first_count_reg > second_count_reg) ? second_count_reg
                                                             : first_count_reg;
            nb_reg   <= (first_count_reg > second_count_reg) ? first_count_reg
                                                             : second_count_reg;
            left_reg <= CNT_W'((total + 1'b1) >> 1);
            odd_reg  <= total[0];
        end
        if (cmd.calc_mid)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_wide[CNT_W-1:0];
        end
        if (finish)
        begin
            median_reg <= (cmd.eval && found) ? median_calc : '0;
            error_reg  <= cmd.finish_empty;
        end
    end

    assign status.empty      = (first_count_reg == '0) && (second_count_reg == '0);
    assign status.range_done = (low_reg > high_reg);
    assign status.found      = found;

    assign median_doubled = median_reg;
    assign empty_error    = error_reg;
    assign done           = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CNT_W'(LIST_DEPTH)) && (second_count_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (first_count_reg == '0) && (second_count_reg == '0))
        else $error("counts not cleared with result");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc_mid |=> (m1_reg <= na_reg) && (m2_reg <= nb_reg))
        else $error("partition point outside list");

endmodule

// ===== hdl/median_of_two_sorted_lists_unit.sv =====
// Median of two ascending lists of signed 32-bit values.
// Drive action and value with start; a beat is taken on a rising edge with
// start high and busy low. Action 0 and 1 append value to the first or the
// second list (up to 1024 entries each; further pushes are dropped), so
// lists load at one beat per cycle. Action 3 is ignored.
// Action 2 computes twice the median of the union as an exact 33-bit value.
// busy stays high while the partition search over the shorter list runs:
// each bisection step passes through a bounds check, a store read and a
// compare, with at most floor(log2(shorter length + 1)) + 1 steps; the result
// is registered after the compare that finds a valid cut, or after the
// bounds check that finds no cut left.
// With both lists empty, empty_error is raised and the result follows in the
// next cycle. After a compute both lists are empty again.
// The result is shown on median_doubled and empty_error for one cycle with
// done high; the receiver cannot stall, so it must take it then. A new beat
// may be taken in the same cycle as done.
// Reset empties both lists and returns the unit to idle; list contents are
// not cleared.
module median_of_two_sorted_lists_unit
    import msl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [1:0]               action,
    input  logic signed [DATA_W-1:0] value,
    output logic                     busy,
    output logic                     done,
    output logic signed [RES_W-1:0]  median_doubled,
    output logic                     empty_error
);

    msl_cmd_t    cmd;
    msl_status_t status;

    msl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    msl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .value          (value),
        .cmd            (cmd),
        .status         (status),
        .median_doubled (median_doubled),
        .empty_error    (empty_error),
        .done           (done)
    );

endmodule

// ===== tb/median_of_two_sorted_lists_unit_tb.sv =====
`timescale 1ns / 100ps

module median_of_two_sorted_lists_unit_tb
    import msl_pkg::*;
;

    localparam int  ITEM_TARGET    = 1350;
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
    localparam longint NEG_INF = -(64'sd1 <<< 40);
    localparam longint POS_INF = (64'sd1 <<< 40);

    typedef logic signed [DATA_W-1:0] elem_q_t[$];

    typedef struct {
        logic signed [RES_W-1:0] doubled;
        logic                    empty_err;
    } median_result_t;

    class median_predictor;
        logic signed [DATA_W-1:0] first_list[$];
        logic signed [DATA_W-1:0] second_list[$];
        median_result_t           pending_medians[$];
        int mismatches;
        int results_seen;
        int pushes;
        int computes;
        int dropped_pushes;
        int empty_computes;
        int no_partition;

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Partition search over the shorter list; missing neighbours act as infinities.
        function median_result_t twice_median();
            logic signed [DATA_W-1:0] shorter[$];
            logic signed [DATA_W-1:0] longer[$];
            int ns, nl, total, left_size, low, high, cut_s, cut_l;
            longint l_s, r_s, l_l, r_l, left_max, right_min, sum;
            median_result_t res;
            res.doubled   = '0;
            res.empty_err = 1'b0;
            if (first_list.size() == 0 && second_list.size() == 0)
            begin
                res.empty_err = 1'b1;
                empty_computes++;
                return res;
            end
            if (first_list.size() > second_list.size())
            begin
                shorter = second_list;
                longer  = first_list;
            end
            else
            begin
                shorter = first_list;
                longer  = second_list;
            end
            ns        = shorter.size();
            nl        = longer.size();
            total     = ns + nl;
            left_size = (total + 1) / 2;
            low       = 0;
            high      = ns;
            while (low <= high)
            begin
                cut_s = (low + high) / 2;
                cut_l = left_size - cut_s;
                l_s = (cut_s >= 1 && cut_s <= ns) ? longint'(shorter[cut_s-1]) : NEG_INF;
                r_s = (cut_s >= 0 && cut_s <  ns) ? longint'(shorter[cut_s])   : POS_INF;
                l_l = (cut_l >= 1 && cut_l <= nl) ? longint'(longer[cut_l-1])  : NEG_INF;
                r_l = (cut_l >= 0 && cut_l <  nl) ? longint'(longer[cut_l])    : POS_INF;
                if (l_s <= r_l && l_l <= r_s)
                begin
                    left_max  = (l_s > l_l) ? l_s : l_l;
                    right_min = (r_s < r_l) ? r_s : r_l;
                    sum = (total % 2 == 1) ? 2 * left_max : left_max + right_min;
                    res.doubled = sum[RES_W-1:0];
                    return res;
                end
                else if (l_s > r_l)
                    high = cut_s - 1;
                else
                    low = cut_s + 1;
            end
            no_partition++;
            return res;
        endfunction

        function void note_beat(logic [1:0] act, logic signed [DATA_W-1:0] val);
            case (msl_action_t'(act))
                ACT_PUSH_FIRST:
                begin
                    pushes++;
                    if (first_list.size() < LIST_DEPTH)
                        first_list.push_back(val);
                    else
                        dropped_pushes++;
                end
                ACT_PUSH_SECOND:
                begin
                    pushes++;
                    if (second_list.size() < LIST_DEPTH)
                        second_list.push_back(val);
                    else
                        dropped_pushes++;
                end
                ACT_COMPUTE:
                begin
                    computes++;
                    pending_medians.push_back(twice_median());
                    first_list.delete();
                    second_list.delete();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [RES_W-1:0] got_doubled, logic got_err);
            median_result_t want;
            results_seen++;
            if (pending_medians.size() == 0)
            begin
                flag_mismatch($sformatf("result %0d / empty_error %b with none pending",
                                        got_doubled, got_err));
                return;
            end
            want = pending_medians.pop_front();
            if (got_doubled !== want.doubled)
                flag_mismatch($sformatf("median_doubled expected %0d got %0d",
                                        want.doubled, got_doubled));
            if (got_err !== want.empty_err)
                flag_mismatch($sformatf("empty_error expected %b got %b",
                                        want.empty_err, got_err));
        endfunction

        function int outstanding();
            return pending_medians.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
    logic                     busy;
    logic                     done;
    logic signed [RES_W-1:0]  median_doubled;
    logic                     empty_error;

    median_predictor predictor = new();
    int burst_left;
    int random_items;
    int idle_cycles;

    median_of_two_sorted_lists_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .value          (value),
        .busy           (busy),
        .done           (done),
        .median_doubled (median_doubled),
        .empty_error    (empty_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results first: a beat taken in the same cycle as done belongs to a later compute.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (done === 1'b1)
            begin
                predictor.check_result(median_doubled, empty_error);
                idle_cycles = 0;
            end
            if (start && !busy)
            begin
                predictor.note_beat(action, value);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat or result for %0d cycles", WATCHDOG_LIMIT);
                $display("** median_of_two_sorted_lists_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_beat(input msl_action_t act, input logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            start  <= 1'b0;
            action <= 2'($urandom);
            value  <= $urandom;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        // hold until busy drops
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (predictor.outstanding() != 0);
        burst_left = 0;
    endtask

    function automatic elem_q_t make_list(int count, bit scrambled);
        elem_q_t          vals;
        longint           cur;
        int unsigned      step_max;
        int               pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            cur = longint'(INT_MIN);
        else if (pick == 1)
            cur = longint'(INT_MAX) - $urandom_range(0, 20);
        else
            cur = longint'($signed(32'($urandom)));
        case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 4;
            2:       step_max = 100000;
            default: step_max = 32'h7fff_ffff;
        endcase
        for (int i = 0; i < count; i++)
        begin
            if (scrambled)
                vals.push_back($urandom);
            else
            begin
                vals.push_back(cur[DATA_W-1:0]);
                cur = cur + $urandom_range(0, step_max);
                if (cur > longint'(INT_MAX))
                    cur = longint'(INT_MAX);
            end
        end
        return vals;
    endfunction

    task automatic run_random_set(input bit overflow_set);
        elem_q_t first_vals, second_vals;
        int n_first, n_second, shape, i1, i2;
        shape = $urandom_range(0, 99);
        if (overflow_set)
        begin
            n_first  = LIST_DEPTH + $urandom_range(1, 5);
            n_second = $urandom_range(0, 6);
            if ($urandom_range(0, 1))
            begin
                n_second = n_first;
                n_first  = $urandom_range(0, 6);
            end
        end
        else if (shape < 4)
        begin
            n_first  = 0;
            n_second = 0;
        end
        else if (shape < 12)
        begin
            n_first  = $urandom_range(0, 64);
            n_second = $urandom_range(0, 64);
        end
        else
        begin
            n_first  = $urandom_range(0, 10);
            n_second = $urandom_range(0, 10);
        end
        first_vals  = make_list(n_first,  $urandom_range(0, 9) == 0);
        second_vals = make_list(n_second, $urandom_range(0, 9) == 0);
        i1 = 0;
        i2 = 0;
        // interleave the two lists, keeping each in its own order, with occasional ignored beats
        while (i1 < n_first || i2 < n_second)
        begin
            if ($urandom_range(0, 29) == 0)
                send_beat(ACT_NONE, $urandom);
            else if (i2 >= n_second || (i1 < n_first && $urandom_range(0, 1)))
            begin
                send_beat(ACT_PUSH_FIRST, first_vals[i1]);
                i1++;
                random_items++;
            end
            else
            begin
                send_beat(ACT_PUSH_SECOND, second_vals[i2]);
                i2++;
                random_items++;
            end
        end
        send_beat(ACT_COMPUTE, $urandom);
        random_items++;
    endtask

    initial
    begin
        int set_no;
        int overflow_at;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_NONE;
        value       = '0;
        burst_left  = 0;
        idle_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, duplicates, odd and even totals, one list empty, unsorted data
        send_beat(ACT_COMPUTE, 32'sd0);
        send_beat(ACT_PUSH_FIRST, INT_MIN);
        send_beat(ACT_COMPUTE, INT_MAX);
        send_beat(ACT_PUSH_SECOND, INT_MAX);
        send_beat(ACT_COMPUTE, INT_MIN);
        send_beat(ACT_PUSH_FIRST, INT_MIN);
        send_beat(ACT_PUSH_SECOND, INT_MAX);
        send_beat(ACT_COMPUTE, 32'sd0);
        send_beat(ACT_PUSH_FIRST, INT_MAX);
        send_beat(ACT_PUSH_FIRST, INT_MAX);
        send_beat(ACT_PUSH_SECOND, INT_MAX);
        send_beat(ACT_COMPUTE, 32'sd0);
        send_beat(ACT_NONE, -32'sd1);
        send_beat(ACT_PUSH_FIRST, -32'sd5);
        send_beat(ACT_PUSH_FIRST, 32'sd3);
        send_beat(ACT_PUSH_SECOND, 32'sd1);
        send_beat(ACT_PUSH_SECOND, 32'sd7);
        send_beat(ACT_COMPUTE, 32'sd0);
        send_beat(ACT_PUSH_FIRST, 32'sd9);
        send_beat(ACT_PUSH_FIRST, -32'sd4);
        send_beat(ACT_PUSH_FIRST, 32'sd2);
        send_beat(ACT_PUSH_SECOND, 32'sd0);
        send_beat(ACT_COMPUTE, 32'sd0);
        send_beat(ACT_PUSH_SECOND, -32'sd1);
        send_beat(ACT_COMPUTE, 32'sd0);
        drain_results();

        random_items = 0;
        set_no       = 0;
        overflow_at  = $urandom_range(3, 15);
        while (random_items < ITEM_TARGET)
        begin
            run_random_set(set_no == overflow_at);
            set_no++;
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pushes (%0d dropped on a full list), %0d computes (%0d empty, %0d unsorted",
                 predictor.pushes, predictor.dropped_pushes, predictor.computes,
                 predictor.empty_computes, predictor.no_partition);
        $display("with no partition), %0d results checked, %0d mismatches",
                 predictor.results_seen, predictor.mismatches);
        if (predictor.mismatches == 0 && predictor.outstanding() == 0)
            $display("** median_of_two_sorted_lists_unit: PASSED **");
        else
            $display("** median_of_two_sorted_lists_unit: FAILED **");
        $finish;
    end

endmodule
